FILE: hdl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg - shared types and constants of the 3D line stepper
// Coordinate widths, word types of both channels, axis codes and the
// per-axis move code table.
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int COORD_WIDTH = 16;
	// error terms span roughly (-2*max, 2*max]
	localparam int ERR_WIDTH = COORD_WIDTH + 3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// direction bits of the move code: x+, y+, z-
	localparam logic [5:0] DIR_MASK = 6'd42;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic                          cmd;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
		logic signed [COORD_WIDTH-1:0] target_z;
	} cmd_word_t;

	typedef struct packed {
		logic [5:0] move_code;
		logic [5:0] stop_code;
		logic       stepped;
		logic       last;
		logic       rejected;
	} move_word_t;

	// step and direction bits for one axis
	function automatic logic [5:0] axis_step_code(input logic [1:0] axis, input logic neg);
		logic [5:0] bits;
		unique case (axis)
			AXIS_X:  bits = neg ? 6'd1 : 6'd3;
			AXIS_Y:  bits = neg ? 6'd4 : 6'd12;
			default: bits = neg ? 6'd48 : 6'd16;
		endcase
		return bits;
	endfunction

	// lead code three behaves as z
	function automatic axis_t lead_norm(input axis_t lead);
		axis_t ax;
		unique case (lead)
			AXIS_X:  ax = AXIS_X;
			AXIS_Y:  ax = AXIS_Y;
			default: ax = AXIS_Z;
		endcase
		return ax;
	endfunction

	function automatic axis_t minor_first(input axis_t lead);
		axis_t ax;
		unique case (lead)
			AXIS_Y:  ax = AXIS_X;
			default: ax = AXIS_Y;
		endcase
		return ax;
	endfunction

	function automatic axis_t minor_second(input axis_t lead);
		axis_t ax;
		unique case (lead)
			AXIS_X:  ax = AXIS_Z;
			AXIS_Y:  ax = AXIS_Z;
			default: ax = AXIS_X;
		endcase
		return ax;
	endfunction

endpackage

FILE: hdl/lsd_if.sv
// ----------------------------------------------------------------------------
// lsd_if - valid/ready channels of the 3D line stepper
// Command channel (load or tick) and move result channel.
// ----------------------------------------------------------------------------
interface lsd_cmd_if import lsd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic signed [COORD_WIDTH-1:0] target_z;

	modport source (output valid, cmd, target_x, target_y, target_z, input ready);
	modport sink   (input valid, cmd, target_x, target_y, target_z, output ready);
endinterface

interface lsd_move_if ();
	logic       valid;
	logic       ready;
	logic [5:0] move_code;
	logic [5:0] stop_code;
	logic       stepped;
	logic       last;
	logic       rejected;

	modport source (output valid, move_code, stop_code, stepped, last, rejected, input ready);
	modport sink   (input valid, move_code, stop_code, stepped, last, rejected, output ready);
endinterface

FILE: hdl/line_stepper_3d.sv
// ----------------------------------------------------------------------------
// line_stepper_3d - 3D Bresenham line generator for stepper motors
// A load word sets a new target; a tick word in a running line steps the lead
// axis once and each minor axis with a positive error, giving one move word.
// ----------------------------------------------------------------------------
// Takes one command word per cycle unless the sink stalls, and returns one
// move word per command via the input register, then the result register.
// The step core updates its line state as each word enters the result
// register, so back to back ticks run at one step per clock unless the sink
// stalls; the result register lets the next command enter while a move word
// waits for the sink. Each line of target minus position takes exactly
// max|delta| ticks; loads while a line runs are dropped, flagged as rejected.
module line_stepper_3d import lsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lsd_cmd_if.sink     cmd_ch,
	lsd_move_if.source  move_ch
);

	cmd_word_t  word_s1;
	logic       valid_s1;
	move_word_t res;
	move_word_t res_q;
	logic       res_valid_q;
	logic       adv;
	logic       fire;

	assign adv          = !res_valid_q || move_ch.ready;
	assign fire         = valid_s1 && adv;
	assign cmd_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_ch.ready) begin
				valid_s1 <= cmd_ch.valid;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			word_s1 <= '{cmd:      cmd_ch.cmd,
			             target_x: cmd_ch.target_x,
			             target_y: cmd_ch.target_y,
			             target_z: cmd_ch.target_z};
		end
		if (fire) begin
			res_q <= res;
		end
	end

	lsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.res    (res)
	);

	assign move_ch.valid     = res_valid_q;
	assign move_ch.move_code = res_q.move_code;
	assign move_ch.stop_code = res_q.stop_code;
	assign move_ch.stepped   = res_q.stepped;
	assign move_ch.last      = res_q.last;
	assign move_ch.rejected  = res_q.rejected;

endmodule

FILE: hdl/lsd_core.sv
// ----------------------------------------------------------------------------
// lsd_core - Bresenham state and step logic
// Holds position, lead axis, error terms and step count; applies one
// command word per fire strobe and presents its result combinationally.
// ----------------------------------------------------------------------------
module lsd_core import lsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  cmd_word_t  word,
	output move_word_t res
);

	logic signed [COORD_WIDTH-1:0] pos_q [3];
	logic        [COORD_WIDTH-1:0] mag_q [3];
	axis_t                         lead_q;
	logic        [2:0]             neg_q;
	logic signed [ERR_WIDTH-1:0]   err_a_q;
	logic signed [ERR_WIDTH-1:0]   err_b_q;
	logic        [COORD_WIDTH-1:0] steps_q;
	logic                          busy_q;

	// load path
	logic signed [COORD_WIDTH-1:0] tgt     [3];
	logic signed [COORD_WIDTH:0]   diff    [3];
	logic        [COORD_WIDTH-1:0] ld_mag  [3];
	logic        [2:0]             ld_neg;
	axis_t                         ld_lead;
	axis_t                         ld_ma;
	axis_t                         ld_mb;
	logic signed [ERR_WIDTH-1:0]   ld_err_a;
	logic signed [ERR_WIDTH-1:0]   ld_err_b;
	logic        [COORD_WIDTH-1:0] ld_steps;

	// tick path
	axis_t                         lead;
	axis_t                         ma;
	axis_t                         mb;
	logic signed [ERR_WIDTH-1:0]   tw_lead;
	logic signed [ERR_WIDTH-1:0]   tw_a;
	logic signed [ERR_WIDTH-1:0]   tw_b;
	logic                          a_pos;
	logic                          b_pos;
	logic signed [ERR_WIDTH-1:0]   err_a_n;
	logic signed [ERR_WIDTH-1:0]   err_b_n;
	logic        [2:0]             stepv;
	logic signed [COORD_WIDTH-1:0] pos_n   [3];
	logic        [5:0]             mv;

	assign tgt[0] = word.target_x;
	assign tgt[1] = word.target_y;
	assign tgt[2] = word.target_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = {tgt[k][COORD_WIDTH-1], tgt[k]} - {pos_q[k][COORD_WIDTH-1], pos_q[k]};
			ld_neg[k] = diff[k][COORD_WIDTH];
			ld_mag[k] = ld_neg[k] ? (~diff[k][COORD_WIDTH-1:0] + 1'b1)
			                      : diff[k][COORD_WIDTH-1:0];
		end
		// ties go to x, then y
		if (ld_mag[0] >= ld_mag[1] && ld_mag[0] >= ld_mag[2]) begin
			ld_lead = AXIS_X;
		end else if (ld_mag[1] >= ld_mag[2]) begin
			ld_lead = AXIS_Y;
		end else begin
			ld_lead = AXIS_Z;
		end
		ld_ma    = minor_first(ld_lead);
		ld_mb    = minor_second(ld_lead);
		ld_steps = ld_mag[ld_lead];
		ld_err_a = $signed({2'b00, ld_mag[ld_ma], 1'b0}) - $signed({3'b000, ld_steps});
		ld_err_b = $signed({2'b00, ld_mag[ld_mb], 1'b0}) - $signed({3'b000, ld_steps});
	end

	always_comb begin
		lead    = lead_norm(lead_q);
		ma      = minor_first(lead);
		mb      = minor_second(lead);
		tw_lead = $signed({2'b00, mag_q[lead], 1'b0});
		tw_a    = $signed({2'b00, mag_q[ma], 1'b0});
		tw_b    = $signed({2'b00, mag_q[mb], 1'b0});
		a_pos   = !err_a_q[ERR_WIDTH-1] && (err_a_q != '0);
		b_pos   = !err_b_q[ERR_WIDTH-1] && (err_b_q != '0);
		err_a_n = err_a_q - (a_pos ? tw_lead : '0) + tw_a;
		err_b_n = err_b_q - (b_pos ? tw_lead : '0) + tw_b;
		stepv       = '0;
		stepv[lead] = 1'b1;
		if (a_pos) stepv[ma] = 1'b1;
		if (b_pos) stepv[mb] = 1'b1;
		mv = '0;
		for (int k = 0; k < 3; k++) begin
			if (stepv[k]) begin
				mv = mv | axis_step_code(2'(k), neg_q[k]);
			end
			if (!stepv[k]) begin
				pos_n[k] = pos_q[k];
			end else if (neg_q[k]) begin
				pos_n[k] = pos_q[k] - COORD_WIDTH'(1);
			end else begin
				pos_n[k] = pos_q[k] + COORD_WIDTH'(1);
			end
		end
	end

	always_comb begin
		res = '0;
		if (word.cmd == CMD_LOAD) begin
			res.rejected = busy_q;
		end else if (busy_q) begin
			res.move_code = mv;
			res.stop_code = mv & DIR_MASK;
			res.stepped   = 1'b1;
			res.last      = (steps_q == COORD_WIDTH'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
				mag_q[k] <= '0;
			end
			lead_q  <= AXIS_X;
			neg_q   <= '0;
			err_a_q <= '0;
			err_b_q <= '0;
			steps_q <= '0;
			busy_q  <= 1'b0;
		end else if (fire) begin
			if (word.cmd == CMD_LOAD) begin
				if (!busy_q) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= ld_mag[k];
					end
					neg_q   <= ld_neg;
					lead_q  <= ld_lead;
					err_a_q <= ld_err_a;
					err_b_q <= ld_err_b;
					steps_q <= ld_steps;
					busy_q  <= (ld_steps != '0);
				end
			end else if (busy_q) begin
				for (int k = 0; k < 3; k++) begin
					pos_q[k] <= pos_n[k];
				end
				err_a_q <= err_a_n;
				err_b_q <= err_b_n;
				steps_q <= steps_q - COORD_WIDTH'(1);
				if (steps_q == COORD_WIDTH'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// a running line always has steps left; an idle block has none
	a_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (steps_q != '0))
		else $error("busy with zero steps left");

	a_idle_steps: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (steps_q == '0))
		else $error("idle with steps left");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.last) |=> !busy_q)
		else $error("line still running after its last step");

	a_lead_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.stepped) |-> (res.move_code[2*lead] == 1'b1))
		else $error("tick without a lead axis step");

endmodule

FILE: tb/lsd_tb_pkg.sv
// ----------------------------------------------------------------------------
// lsd_tb_pkg - scoreboard of the 3D line stepper testbench
// Keeps its own copy of the stepper state, predicts one move word per
// accepted command word and checks the move words in order.
// ----------------------------------------------------------------------------
package lsd_tb_pkg;
	import lsd_pkg::*;

	class stepper_scoreboard;
		move_word_t expected_moves[$];
		int         pos[3];
		axis_t      lead;
		bit   [2:0] neg_dir;
		int         dbl_delta[3];
		int         err_a;
		int         err_b;
		int         steps_left;
		bit         busy;
		int         errors;

		function new();
			foreach (pos[k]) begin
				pos[k] = 0;
				dbl_delta[k] = 0;
			end
			lead = AXIS_X;
			neg_dir = '0;
			err_a = 0;
			err_b = 0;
			steps_left = 0;
			busy = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return expected_moves.size();
		endfunction

		function void step_axis(input axis_t ax, inout move_word_t w);
			int k;
			bit ng;
			k = int'(ax);
			ng = neg_dir[k];
			pos[k] += ng ? -1 : 1;
			w.move_code[2*k] = 1'b1;
			// z runs the other way round on the direction bit
			w.move_code[2*k+1] = (ax == AXIS_Z) ? ng : !ng;
		endfunction

		function void note_cmd(input cmd_word_t c);
			move_word_t w;
			int         tgt[3];
			int         mag[3];
			axis_t      ma;
			axis_t      mb;
			w = '0;
			if (c.cmd == CMD_LOAD) begin
				if (busy) begin
					w.rejected = 1'b1;
				end else begin
					tgt[0] = c.target_x;
					tgt[1] = c.target_y;
					tgt[2] = c.target_z;
					neg_dir = '0;
					for (int k = 0; k < 3; k++) begin
						mag[k] = tgt[k] - pos[k];
						if (mag[k] < 0) begin
							neg_dir[k] = 1'b1;
							mag[k] = -mag[k];
						end
						dbl_delta[k] = 2 * mag[k];
					end
					if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
						lead = AXIS_X;
						err_a = dbl_delta[1] - mag[0];
						err_b = dbl_delta[2] - mag[0];
						steps_left = mag[0];
					end else if (mag[1] >= mag[2]) begin
						lead = AXIS_Y;
						err_a = dbl_delta[0] - mag[1];
						err_b = dbl_delta[2] - mag[1];
						steps_left = mag[1];
					end else begin
						lead = AXIS_Z;
						err_a = dbl_delta[1] - mag[2];
						err_b = dbl_delta[0] - mag[2];
						steps_left = mag[2];
					end
					busy = steps_left > 0;
				end
			end else if (busy) begin
				ma = (lead == AXIS_Y) ? AXIS_X : AXIS_Y;
				mb = (lead == AXIS_Z) ? AXIS_X : AXIS_Z;
				if (err_a > 0) begin
					step_axis(ma, w);
					err_a -= dbl_delta[lead];
				end
				if (err_b > 0) begin
					step_axis(mb, w);
					err_b -= dbl_delta[lead];
				end
				err_a += dbl_delta[ma];
				err_b += dbl_delta[mb];
				step_axis(lead, w);
				w.stop_code = w.move_code & DIR_MASK;
				w.stepped = 1'b1;
				steps_left--;
				if (steps_left <= 0) begin
					steps_left = 0;
					busy = 1'b0;
					w.last = 1'b1;
				end
			end
			expected_moves.push_back(w);
		endfunction

		function void check_move(input move_word_t got);
			move_word_t want;
			if (expected_moves.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: move word with none expected: move=%0d stop=%0d", $time,
						got.move_code, got.stop_code);
				return;
			end
			want = expected_moves.pop_front();
			if (got.move_code !== want.move_code || got.stop_code !== want.stop_code ||
					got.stepped !== want.stepped || got.last !== want.last ||
					got.rejected !== want.rejected) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: move word mismatch: expected move=%0d stop=%0d stepped=%0b ",
						"last=%0b rejected=%0b, got move=%0d stop=%0d stepped=%0b last=%0b ",
						"rejected=%0b"}, $time, want.move_code, want.stop_code, want.stepped,
						want.last, want.rejected, got.move_code, got.stop_code, got.stepped,
						got.last, got.rejected);
			end
		endfunction

		function void check_leftover();
			if (expected_moves.size() != 0) begin
				errors += expected_moves.size();
				$display("%0t: %0d move words never arrived", $time, expected_moves.size());
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_line_stepper_3d.sv
// ----------------------------------------------------------------------------
// tb_line_stepper_3d - testbench of the 3D line stepper
// Drives load and tick words with random gaps and sink stalls, predicts every
// move word in a scoreboard and checks them in order. Covers short lines of
// every lead axis, ties, rejected loads, idle ticks and two long lines.
// ----------------------------------------------------------------------------
module tb_line_stepper_3d;
	import lsd_pkg::*;
	import lsd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;

	lsd_cmd_if  cmd_ch ();
	lsd_move_if move_ch ();

	line_stepper_3d dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.move_ch (move_ch)
	);

	stepper_scoreboard sb = new();

	bit idling_on = 1'b0;
	int hold_req = 0;
	int items_sent = 0;
	int cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin : move_monitor
		move_word_t got;
		if (arst_n === 1'b1 && move_ch.valid === 1'b1 && move_ch.ready === 1'b1) begin
			got.move_code = move_ch.move_code;
			got.stop_code = move_ch.stop_code;
			got.stepped = move_ch.stepped;
			got.last = move_ch.last;
			got.rejected = move_ch.rejected;
			sb.check_move(got);
		end
	end

	// sink side: random stalls, plus a long hold-off on request
	initial begin : sink_ready
		int n;
		move_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				move_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				move_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				move_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_word(input cmd_word_t w);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= w.cmd;
		cmd_ch.target_x <= w.target_x;
		cmd_ch.target_y <= w.target_y;
		cmd_ch.target_z <= w.target_z;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_cmd(w);
		items_sent++;
	endtask

	task automatic send_load(input int tx, input int ty, input int tz);
		cmd_word_t w;
		w.cmd = CMD_LOAD;
		w.target_x = COORD_WIDTH'(tx);
		w.target_y = COORD_WIDTH'(ty);
		w.target_z = COORD_WIDTH'(tz);
		send_word(w);
	endtask

	// tick words carry random junk in the target fields
	task automatic send_tick();
		cmd_word_t w;
		w.cmd = CMD_TICK;
		w.target_x = COORD_WIDTH'($urandom());
		w.target_y = COORD_WIDTH'($urandom());
		w.target_z = COORD_WIDTH'($urandom());
		send_word(w);
	endtask

	// full-range target; only sent while a line runs, so it gets rejected
	task automatic send_stray_load();
		send_load($urandom(), $urandom(), $urandom());
	endtask

	task automatic finish_line(input bit strays);
		while (sb.busy) begin
			if (strays && $urandom_range(0, 3) == 0)
				send_stray_load();
			send_tick();
		end
	endtask

	task automatic wait_all_moves();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic int clamp_coord(input int v);
		int lo;
		int hi;
		lo = -(1 << (COORD_WIDTH - 1));
		hi = (1 << (COORD_WIDTH - 1)) - 1;
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// load a target a short way off the current position
	task automatic load_near();
		int d[3];
		int m;
		int sel;
		sel = $urandom_range(0, 19);
		foreach (d[k]) d[k] = 0;
		if (sel < 12) begin
			foreach (d[k]) d[k] = int'($urandom_range(0, 24)) - 12;
		end else if (sel < 15) begin
			// two or three axes with equal magnitude
			m = $urandom_range(1, 15);
			foreach (d[k]) d[k] = $urandom_range(0, 1) ? m : -m;
			if ($urandom_range(0, 1))
				d[$urandom_range(0, 2)] = int'($urandom_range(0, m - 1));
		end else if (sel < 17) begin
			d[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1 : -1) *
				int'($urandom_range(1, 30));
		end else if (sel < 19) begin
			foreach (d[k]) d[k] = int'($urandom_range(0, 600)) - 300;
		end
		send_load(clamp_coord(sb.pos[0] + d[0]), clamp_coord(sb.pos[1] + d[1]),
			clamp_coord(sb.pos[2] + d[2]));
	endtask

	task automatic random_items(input int count);
		int stop_at;
		int r;
		int n;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				load_near();
				finish_line($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 6) == 0)
					send_tick();
			end else if (r < 85) begin
				if ($urandom_range(0, 1))
					send_tick();
				else
					send_load(sb.pos[0], sb.pos[1], sb.pos[2]);
			end else begin
				// cut into a running line with a load, then run it out
				load_near();
				n = $urandom_range(0, sb.steps_left);
				repeat (n) send_tick();
				if (sb.busy)
					send_stray_load();
				finish_line(1'b0);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.cmd <= CMD_LOAD;
		cmd_ch.target_x <= '0;
		cmd_ch.target_y <= '0;
		cmd_ch.target_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, load onto the position, each lead axis, a tie
		send_tick();
		send_load(0, 0, 0);
		send_tick();
		send_load(3, -2, 1);
		send_tick();
		send_load(32767, -32768, -1);
		send_load(-32768, 32767, 0);
		finish_line(1'b0);
		send_load(1, 5, -1);
		finish_line(1'b0);
		send_load(1, 5, -5);
		finish_line(1'b0);
		send_load(3, 8, -2);
		finish_line(1'b0);
		send_tick();

		idling_on = 1'b1;
		random_items(450);
		// long sink hold-off while words keep coming
		hold_req = 400;
		random_items(450);
		wait_all_moves();
		repeat ($urandom_range(1, 11)) @(posedge clk);
		random_items(400);

		// no idling from here on; two long lines, out and back
		idling_on = 1'b0;
		send_load(clamp_coord(sb.pos[0] - 230), clamp_coord(sb.pos[1] + 160),
			clamp_coord(sb.pos[2] - 95));
		finish_line(1'b0);
		send_load(clamp_coord(sb.pos[0] + 230), clamp_coord(sb.pos[1] - 160),
			clamp_coord(sb.pos[2] + 95));
		if (sb.busy)
			send_stray_load();
		finish_line(1'b0);
		random_items(100);

		wait_all_moves();
		repeat (20) @(posedge clk);
		sb.check_leftover();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
